// File: rtl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
`default_nettype none
package mlfq_pkg;
  localparam int CmdW = 1;
  localparam int TidW = 4;
  localparam int PrioW = 2;
  localparam int SpW = 32;
  localparam int StW = 2;
  localparam int StatW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int QuantW = 16;
  localparam int BoostW = 32;

  localparam logic [CmdW-1:0] CMD_ADD = 1'b0;
  localparam logic [CmdW-1:0] CMD_TICK = 1'b1;

  localparam logic [StW-1:0] ST_RUNNING = 2'd0;
  localparam logic [StW-1:0] ST_READY = 2'd1;

  localparam logic [StatW-1:0] STAT_KEEP = 2'd0;
  localparam logic [StatW-1:0] STAT_SWITCH = 2'd1;
  localparam logic [StatW-1:0] STAT_HALT = 2'd2;
  localparam logic [StatW-1:0] STAT_ADDED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_QUANTUM = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BOOST = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the request
    logic add_op;      // perform add (store sp + push)
    logic tick_pre;    // boost count, save sp, slice charge
    logic boost_step;  // splice one low level onto the top
    logic requeue;     // push running thread back
    logic pop;         // pop highest level, form result
    logic emit_keep;   // result: keep / disabled tick
    logic emit_add;    // result: added
  } mlfq_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic is_tick;
    logic enabled;
    logic boost_hit;   // boost count reached threshold
    logic boost_last;  // current splice level is the last one
    logic keep_slot;   // running thread keeps its slice
    logic do_requeue;  // running thread goes back to a queue
  } mlfq_stat_t;
endpackage
`default_nettype wire

// File: rtl/mlfq_if.sv
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface mlfq_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/mlfq_ctrl.sv
// Controller state machine sequencing add and tick requests.
`default_nettype none
module mlfq_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output mlfq_pkg::mlfq_cmd_t cmd,
  input  wire mlfq_pkg::mlfq_stat_t stat
);
  import mlfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_BOOST, S_REQUEUE, S_POP, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Accept only when the result register is free or being taken this cycle
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_tick) begin
          cmd.add_op = 1'b1;
          cmd.emit_add = 1'b1;
          state_nxt = S_OUT;
        end else if (!stat.enabled) begin
          cmd.emit_keep = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.tick_pre = 1'b1;
          state_nxt = stat.boost_hit ? S_BOOST : S_REQUEUE;
        end
      end
      S_BOOST: begin
        cmd.boost_step = 1'b1;
        if (stat.boost_last) state_nxt = S_REQUEUE;
      end
      S_REQUEUE: begin
        if (stat.keep_slot) begin
          cmd.emit_keep = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.requeue = stat.do_requeue;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("ready while busy");
  a_boost_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BOOST |-> $past(state_r) == S_DECODE || $past(state_r) == S_BOOST)
    else $error("bad boost entry");
endmodule
`default_nettype wire

// File: rtl/mlfq_dp.sv
// Datapath: queue links, stack store, level pointers and counters.
`default_nettype none
module mlfq_dp #(
  parameter int LEVELS = 4,
  parameter int THREADS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [mlfq_pkg::CmdW-1:0] in_command,
  input  wire logic [mlfq_pkg::TidW-1:0] in_thread_id,
  input  wire logic [mlfq_pkg::PrioW-1:0] in_priority_req,
  input  wire logic [mlfq_pkg::SpW-1:0] in_stack_pointer,
  input  wire logic [mlfq_pkg::StW-1:0] in_current_state,
  input  wire logic cfg_enable,
  input  wire logic [mlfq_pkg::QuantW-1:0] cfg_quantum_v,
  input  wire logic [mlfq_pkg::BoostW-1:0] cfg_boost_v,
  input  wire mlfq_pkg::mlfq_cmd_t cmd,
  output mlfq_pkg::mlfq_stat_t stat,
  output logic [mlfq_pkg::StatW-1:0] out_status,
  output logic [mlfq_pkg::TidW-1:0] out_next_thread,
  output logic [mlfq_pkg::SpW-1:0] out_next_stack_pointer
);
  import mlfq_pkg::*;

  localparam int IdW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LvW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LvW-1:0] TOP = LvW'(LEVELS - 1);

  // Captured request
  logic             cmd_r;
  logic [TidW-1:0]  tid_r;
  logic [PrioW-1:0] prio_r;
  logic [SpW-1:0]   sp_r;
  logic [StW-1:0]   st_r;

  logic [IdW-1:0] link_r [THREADS];
  logic [SpW-1:0] stack_r [THREADS];
  logic [IdW-1:0] head_r [LEVELS];
  logic [IdW-1:0] tail_r [LEVELS];
  logic [LEVELS-1:0] nonempty_r;
  logic [IdW-1:0] run_id_r;
  logic           run_valid_r;
  logic [LvW-1:0] run_lvl_r;
  logic [QuantW-1:0] slice_r;
  logic [BoostW-1:0] boost_cnt_r;
  logic [LvW-1:0] bst_lvl_r;
  logic           keep_r, reque_r;
  logic [StatW-1:0] res_stat_r;
  logic [TidW-1:0]  res_tid_r;
  logic [SpW-1:0]   res_sp_r;

  logic [BoostW-1:0] boost_inc;
  logic [QuantW-1:0] slice_inc;
  logic [LvW-1:0]    add_lvl, push_lvl, demote_lvl, pop_lvl;
  logic              pop_any;
  logic [IdW-1:0]    pop_id;

  assign boost_inc = boost_cnt_r + 1'b1;
  assign slice_inc = slice_r + 1'b1;
  assign demote_lvl = (run_lvl_r != '0) ? run_lvl_r - 1'b1 : run_lvl_r;

  // Saturate requested priority to top level
  always_comb begin
    if (32'(prio_r) > 32'(LEVELS - 1)) add_lvl = TOP;
    else add_lvl = LvW'(prio_r);
  end

  // Highest non-empty level
  always_comb begin
    pop_any = 1'b0;
    pop_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (nonempty_r[l]) begin
        pop_any = 1'b1;
        pop_lvl = LvW'(l);
      end
    end
  end
  assign pop_id = head_r[pop_lvl];
  assign push_lvl = cmd.add_op ? add_lvl : run_lvl_r;

  assign stat.is_tick = (cmd_r == CMD_TICK);
  assign stat.enabled = cfg_enable;
  assign stat.boost_hit = (boost_inc >= cfg_boost_v);
  assign stat.boost_last = (bst_lvl_r == TOP - 1'b1);
  assign stat.keep_slot = keep_r;
  assign stat.do_requeue = reque_r;

  assign out_status = res_stat_r;
  assign out_next_thread = res_tid_r;
  assign out_next_stack_pointer = res_sp_r;

  // Payload registers and memories
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      tid_r <= in_thread_id;
      prio_r <= in_priority_req;
      sp_r <= in_stack_pointer;
      st_r <= in_current_state;
    end
    if (cmd.add_op && 32'(tid_r) < THREADS) begin
      stack_r[IdW'(tid_r)] <= sp_r;
      if (nonempty_r[add_lvl]) link_r[tail_r[add_lvl]] <= IdW'(tid_r);
    end
    if (cmd.tick_pre && run_valid_r) stack_r[run_id_r] <= sp_r;
    if (cmd.boost_step && nonempty_r[bst_lvl_r] && nonempty_r[TOP])
      link_r[tail_r[TOP]] <= head_r[bst_lvl_r];
    if (cmd.requeue && nonempty_r[push_lvl]) link_r[tail_r[push_lvl]] <= run_id_r;
    if (cmd.emit_add) begin
      res_stat_r <= STAT_ADDED;
      res_tid_r <= '0;
      res_sp_r <= '0;
    end
    if (cmd.emit_keep) begin
      res_stat_r <= STAT_KEEP;
      res_tid_r <= run_valid_r ? TidW'(run_id_r) : '0;
      res_sp_r <= sp_r;
    end
    if (cmd.pop) begin
      res_stat_r <= pop_any ? STAT_SWITCH : STAT_HALT;
      res_tid_r <= pop_any ? TidW'(pop_id) : '0;
      res_sp_r <= pop_any ? stack_r[pop_id] : '0;
    end
  end

  // Control state: queue pointers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
      end
      nonempty_r <= '0;
      run_id_r <= '0;
      run_valid_r <= 1'b0;
      run_lvl_r <= '0;
      slice_r <= '0;
      boost_cnt_r <= '0;
      bst_lvl_r <= '0;
      keep_r <= 1'b0;
      reque_r <= 1'b0;
    end else begin
      if (cmd.add_op && 32'(tid_r) < THREADS) begin
        tail_r[add_lvl] <= IdW'(tid_r);
        if (!nonempty_r[add_lvl]) begin
          head_r[add_lvl] <= IdW'(tid_r);
          nonempty_r[add_lvl] <= 1'b1;
        end
      end
      if (cmd.tick_pre) begin
        bst_lvl_r <= '0;
        boost_cnt_r <= stat.boost_hit ? '0 : boost_inc;
        keep_r <= 1'b0;
        reque_r <= 1'b0;
        if (run_valid_r) begin
          if (st_r == ST_RUNNING) begin
            slice_r <= slice_inc;
            if (slice_inc < cfg_quantum_v) keep_r <= 1'b1;
            else begin
              run_lvl_r <= demote_lvl;
              reque_r <= 1'b1;
            end
          end else if (st_r == ST_READY) reque_r <= 1'b1;
        end
      end
      if (cmd.boost_step) begin
        bst_lvl_r <= bst_lvl_r + 1'b1;
        if (nonempty_r[bst_lvl_r]) begin
          tail_r[TOP] <= tail_r[bst_lvl_r];
          if (!nonempty_r[TOP]) begin
            head_r[TOP] <= head_r[bst_lvl_r];
            nonempty_r[TOP] <= 1'b1;
          end
          nonempty_r[bst_lvl_r] <= 1'b0;
        end
      end
      if (cmd.requeue) begin
        tail_r[push_lvl] <= run_id_r;
        if (!nonempty_r[push_lvl]) begin
          head_r[push_lvl] <= run_id_r;
          nonempty_r[push_lvl] <= 1'b1;
        end
      end
      if (cmd.pop) begin
        slice_r <= '0;
        run_valid_r <= pop_any;
        if (pop_any) begin
          run_id_r <= pop_id;
          run_lvl_r <= pop_lvl;
          if (pop_id == tail_r[pop_lvl]) nonempty_r[pop_lvl] <= 1'b0;
          else head_r[pop_lvl] <= link_r[pop_id];
        end
      end
    end
  end

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && nonempty_r == '0 |=> !run_valid_r)
    else $error("halt left a running thread");
  a_boost_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.boost_step |=> !nonempty_r[$past(bst_lvl_r)])
    else $error("boost left a low level filled");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_op, cmd.tick_pre, cmd.boost_step, cmd.requeue, cmd.pop}))
    else $error("overlapping datapath commands");
endmodule
`default_nettype wire

// File: rtl/mlfq_thread_scheduler_unit.sv
// Top level of the multilevel feedback queue thread scheduler.
//  channel | dir | fields
//  in      | in  | command, thread_id, priority_req, stack_pointer, current_state
//  out     | out | status, next_thread, next_stack_pointer
//  cfg     | in  | 0 enable, 1 quantum, 2 boost period
// out_valid is registered in S_OUT: an add or a disabled tick passes S_DECODE
// then S_OUT, a tick that keeps its slot also S_REQUEUE, one that pops or halts
// S_REQUEUE and S_POP; S_BOOST splices the LEVELS-1 lower levels one per cycle.
// Reset is synchronous: all queues empty, no thread running, counters zero.
// One request at a time; in_ready is high only when idle with no result
// waiting, or with the waiting result taken in that cycle; a stalled result
// holds until taken.
`default_nettype none
module mlfq_thread_scheduler_unit #(
  parameter int LEVELS = 4,
  parameter int THREADS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mlfq_if.sink   in_ch,
  mlfq_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [mlfq_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [mlfq_pkg::CfgDataW-1:0] cfg_data
);
  import mlfq_pkg::*;

  mlfq_cmd_t  cmd;
  mlfq_stat_t stat;
  logic enable_r;
  logic [QuantW-1:0] quantum_r;
  logic [BoostW-1:0] boost_r;
  logic [StatW-1:0] st_o;
  logic [TidW-1:0] tid_o;
  logic [SpW-1:0] sp_o;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      quantum_r <= QuantW'(10);
      boost_r <= BoostW'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:  enable_r <= cfg_data[0];
        REG_QUANTUM: quantum_r <= cfg_data[QuantW-1:0];
        REG_BOOST:   boost_r <= cfg_data[BoostW-1:0];
        default: ;
      endcase
    end
  end

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  mlfq_dp #(.LEVELS(LEVELS), .THREADS(THREADS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_command(in_ch.data.command),
    .in_thread_id(in_ch.data.thread_id),
    .in_priority_req(in_ch.data.priority_req),
    .in_stack_pointer(in_ch.data.stack_pointer),
    .in_current_state(in_ch.data.current_state),
    .cfg_enable(enable_r), .cfg_quantum_v(quantum_r), .cfg_boost_v(boost_r),
    .cmd(cmd), .stat(stat),
    .out_status(st_o), .out_next_thread(tid_o), .out_next_stack_pointer(sp_o)
  );

  assign out_ch.data.status = st_o;
  assign out_ch.data.next_thread = tid_o;
  assign out_ch.data.next_stack_pointer = sp_o;
endmodule
`default_nettype wire
